// ===== hdl/dbsfb_pkg.sv =====
package dbsfb_pkg;

    typedef enum logic {
        OP_STEP  = 1'b0,
        OP_WRITE = 1'b1
    } t_op;

    localparam int CHAN_W      = 4;
    localparam int SEL_W       = 3;
    localparam int VALUE_W     = 32;
    localparam int COEF_W      = 32;
    localparam int FRAC_BITS   = 28;
    localparam int SPLIT_BITS  = 16;
    localparam int SLOTS       = 8;
    localparam int PAIRS       = 2;
    localparam int PAIR_STRIDE = 4;

    // coefficient slot order inside one pair
    localparam int SLOT_P11  = 0;
    localparam int SLOT_P22  = 1;
    localparam int SLOT_P21  = 2;
    localparam int SLOT_GAIN = 3;

    typedef struct packed {
        t_op                       op;
        logic [CHAN_W-1:0]         channel;
        logic [SEL_W-1:0]          coef_sel;
        logic signed [VALUE_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [CHAN_W-1:0]         out_channel;
        logic signed [VALUE_W-1:0] lfp_sum;
        logic signed [VALUE_W-1:0] g_pair_one;
        logic signed [VALUE_W-1:0] g_pair_two;
    } t_out_item;

endpackage

// ===== hdl/dbsfb_ram.sv =====
module dbsfb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/dbsfb_front.sv =====
module dbsfb_front #(
    parameter int CHANNELS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  dbsfb_pkg::t_in_item i_in_item,
    input  logic                i_hold,
    output logic                o_head_valid,
    output dbsfb_pkg::t_in_item o_head,
    input  logic                i_pop
);

    import dbsfb_pkg::*;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam logic [8:0] CH_LIMIT = 9'(CHANNELS);

    t_in_item            r_queue [QDEPTH];
    logic [QPTR_W:0]     r_count, n_count;
    logic [QPTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic                accept;
    logic                in_range;
    logic                push;

    assign o_in_ready = !i_hold && (r_count != (QPTR_W+1)'(QDEPTH));
    assign accept     = i_in_valid && o_in_ready;
    // channels past the bank are dropped here and never reach the back end
    assign in_range   = (9'(i_in_item.channel) < CH_LIMIT);
    assign push       = accept && in_range;

    assign o_head_valid = (r_count != '0);
    assign o_head       = r_queue[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr + QPTR_W'(push);
        n_rd_ptr = r_rd_ptr + QPTR_W'(i_pop);
        n_count  = r_count + (QPTR_W+1)'(push) - (QPTR_W+1)'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            r_count  <= n_count;
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= i_in_item;
        end
    end

endmodule

// ===== hdl/dbsfb_back.sv =====
module dbsfb_back #(
    parameter int CHANNELS   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_head_valid,
    input  dbsfb_pkg::t_in_item  i_head,
    output logic                 o_pop,
    output logic                 o_clearing,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output dbsfb_pkg::t_out_item o_out_item
);

    import dbsfb_pkg::*;

    localparam int DW    = DATA_WIDTH;
    localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int AW    = (DW > VALUE_W) ? DW : VALUE_W;
    localparam int HI_W  = AW - SPLIT_BITS;
    localparam int HP_W  = HI_W + COEF_W;
    localparam int LP_W  = SPLIT_BITS + 1 + COEF_W;
    localparam int PW    = AW + COEF_W;
    localparam int RW    = PW - FRAC_BITS;
    localparam int SW    = RW + 1;
    localparam int NST   = 2 * PAIRS;
    localparam logic [PW-1:0] ROUND_HALF = PW'(1) << (FRAC_BITS - 1);
    localparam logic signed [DW-1:0] SAT_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] SAT_MIN = {1'b1, {(DW-1){1'b0}}};

    function automatic logic signed [DW-1:0] sat_state(input logic signed [SW-1:0] v);
        logic ovf;
        ovf = (v[SW-1:DW-1] != {(SW-DW+1){v[SW-1]}});
        if (ovf) begin
            return v[SW-1] ? SAT_MIN : SAT_MAX;
        end
        return v[DW-1:0];
    endfunction

    function automatic logic signed [DW-1:0] sat_sum(input logic signed [DW:0] v);
        if (v[DW] != v[DW-1]) begin
            return v[DW] ? SAT_MIN : SAT_MAX;
        end
        return v[DW-1:0];
    endfunction

    // clearing pass
    logic            r_clearing, n_clearing;
    logic [CH_W-1:0] r_clr_idx, n_clr_idx;

    // issue control
    logic            advance;
    logic            is_step;
    logic            hazard;
    logic            issue_step;
    logic            issue_write;
    logic [CH_W-1:0] head_addr;

    // memory read data
    logic signed [COEF_W-1:0] coef_rd [SLOTS];
    logic signed [DW-1:0]     st_rd [NST];
    logic signed [DW-1:0]     st_new [NST];
    logic [CH_W-1:0]          st_waddr;
    logic                     st_we;

    // pipeline
    logic                      r_v1, r_v2, r_v3, r_v4, r_v5;
    logic [CHAN_W-1:0]         r_ch1, r_ch2, r_ch3, r_ch4, r_ch5;
    logic signed [VALUE_W-1:0] r_x1;
    logic signed [AW-1:0]      mul_a [SLOTS];
    logic signed [COEF_W-1:0]  mul_b [SLOTS];
    logic signed [HP_W-1:0]    hi_prod [SLOTS];
    logic signed [LP_W-1:0]    lo_prod [SLOTS];
    logic signed [HP_W-1:0]    r_hi2 [SLOTS];
    logic signed [LP_W-1:0]    r_lo2 [SLOTS];
    logic signed [PW-1:0]      full_prod [SLOTS];
    logic signed [PW-1:0]      r_p3 [SLOTS];
    logic [PW-1:0]             rnd_sum [SLOTS];
    logic signed [RW-1:0]      r_r4 [SLOTS];
    logic signed [DW-1:0]      r_g5 [PAIRS];
    logic signed [DW-1:0]      lfp;
    logic                      r_out_valid;
    t_out_item                 r_out_item;

    assign o_clearing  = r_clearing;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    always_comb begin
        n_clearing = r_clearing;
        n_clr_idx  = r_clr_idx;
        if (r_clearing) begin
            n_clr_idx = r_clr_idx + CH_W'(1);
            if (r_clr_idx == CH_W'(CHANNELS - 1)) begin
                n_clearing = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_idx  <= '0;
        end else begin
            r_clearing <= n_clearing;
            r_clr_idx  <= n_clr_idx;
        end
    end

    // the whole back end moves as one while the output slot can take a result
    assign advance   = !r_out_valid || i_out_ready;
    assign is_step   = (i_head.op == OP_STEP);
    assign head_addr = CH_W'(i_head.channel);

    // a step waits while an earlier step of its channel has not written back
    assign hazard = is_step && (
        (r_v1 && (r_ch1 == i_head.channel)) ||
        (r_v2 && (r_ch2 == i_head.channel)) ||
        (r_v3 && (r_ch3 == i_head.channel)) ||
        (r_v4 && (r_ch4 == i_head.channel)));

    assign o_pop       = i_head_valid && !r_clearing && advance && !hazard;
    assign issue_step  = o_pop && is_step;
    assign issue_write = o_pop && !is_step;

    for (genvar s = 0; s < SLOTS; s++) begin : g_coef
        logic            we;
        logic [CH_W-1:0] waddr;
        logic [COEF_W-1:0] wdata;

        assign we    = r_clearing || (issue_write && (i_head.coef_sel == SEL_W'(s)));
        assign waddr = r_clearing ? r_clr_idx : head_addr;
        assign wdata = r_clearing ? '0 : i_head.value;

        dbsfb_ram #(
            .WIDTH (COEF_W),
            .DEPTH (CHANNELS)
        ) u_coef_ram (
            .i_clk   (i_clk),
            .i_we    (we),
            .i_waddr (waddr),
            .i_wdata (wdata),
            .i_re    (advance),
            .i_raddr (head_addr),
            .o_rdata (coef_rd[s])
        );
    end

    assign st_we    = advance && r_v4;
    assign st_waddr = CH_W'(r_ch4);

    // state index: 2*pair is the pair output, 2*pair+1 its derivative
    for (genvar j = 0; j < NST; j++) begin : g_state
        logic            we;
        logic [CH_W-1:0] waddr;
        logic [DW-1:0]   wdata;

        assign we    = r_clearing || st_we;
        assign waddr = r_clearing ? r_clr_idx : st_waddr;
        assign wdata = r_clearing ? '0 : st_new[j];

        dbsfb_ram #(
            .WIDTH (DW),
            .DEPTH (CHANNELS)
        ) u_state_ram (
            .i_clk   (i_clk),
            .i_we    (we),
            .i_waddr (waddr),
            .i_wdata (wdata),
            .i_re    (advance),
            .i_raddr (head_addr),
            .o_rdata (st_rd[j])
        );
    end

    // operand routing: per pair d*P21, o*P22, d*P11, x*gain
    always_comb begin
        for (int k = 0; k < PAIRS; k++) begin
            mul_a[PAIR_STRIDE*k + 0] = AW'(st_rd[2*k + 1]);
            mul_b[PAIR_STRIDE*k + 0] = coef_rd[PAIR_STRIDE*k + SLOT_P21];
            mul_a[PAIR_STRIDE*k + 1] = AW'(st_rd[2*k]);
            mul_b[PAIR_STRIDE*k + 1] = coef_rd[PAIR_STRIDE*k + SLOT_P22];
            mul_a[PAIR_STRIDE*k + 2] = AW'(st_rd[2*k + 1]);
            mul_b[PAIR_STRIDE*k + 2] = coef_rd[PAIR_STRIDE*k + SLOT_P11];
            mul_a[PAIR_STRIDE*k + 3] = AW'(r_x1);
            mul_b[PAIR_STRIDE*k + 3] = coef_rd[PAIR_STRIDE*k + SLOT_GAIN];
        end
    end

    // each wide product is split into a signed high and an unsigned low part
    always_comb begin
        for (int j = 0; j < SLOTS; j++) begin
            hi_prod[j] = $signed(mul_a[j][AW-1:SPLIT_BITS]) * mul_b[j];
            lo_prod[j] = $signed({1'b0, mul_a[j][SPLIT_BITS-1:0]}) * mul_b[j];
        end
    end

    always_comb begin
        for (int j = 0; j < SLOTS; j++) begin
            full_prod[j] = (PW'(r_hi2[j]) <<< SPLIT_BITS) + PW'(r_lo2[j]);
        end
    end

    // round half away from zero: negative values take one less before the shift
    always_comb begin
        for (int j = 0; j < SLOTS; j++) begin
            rnd_sum[j] = r_p3[j] + ROUND_HALF - PW'(r_p3[j][PW-1]);
        end
    end

    always_comb begin
        for (int k = 0; k < PAIRS; k++) begin
            st_new[2*k]     = sat_state(SW'(r_r4[PAIR_STRIDE*k + 0])
                                      + SW'(r_r4[PAIR_STRIDE*k + 1]));
            st_new[2*k + 1] = sat_state(SW'(r_r4[PAIR_STRIDE*k + 2])
                                      + SW'(r_r4[PAIR_STRIDE*k + 3]));
        end
    end

    assign lfp = sat_sum((DW+1)'(r_g5[0]) + (DW+1)'(r_g5[1]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_v5        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_v1        <= issue_step;
            r_v2        <= r_v1;
            r_v3        <= r_v2;
            r_v4        <= r_v3;
            r_v5        <= r_v4;
            r_out_valid <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_ch1 <= i_head.channel;
            r_x1  <= i_head.value;
            r_ch2 <= r_ch1;
            r_ch3 <= r_ch2;
            r_ch4 <= r_ch3;
            r_ch5 <= r_ch4;
            for (int j = 0; j < SLOTS; j++) begin
                r_hi2[j] <= hi_prod[j];
                r_lo2[j] <= lo_prod[j];
                r_p3[j]  <= full_prod[j];
                r_r4[j]  <= rnd_sum[j][PW-1:FRAC_BITS];
            end
            for (int k = 0; k < PAIRS; k++) begin
                r_g5[k] <= st_new[2*k];
            end
            r_out_item.out_channel <= r_ch5;
            r_out_item.lfp_sum     <= VALUE_W'(lfp);
            r_out_item.g_pair_one  <= VALUE_W'(r_g5[0]);
            r_out_item.g_pair_two  <= VALUE_W'(r_g5[1]);
        end
    end

endmodule

// ===== hdl/dual_beta_synapse_filter_bank_core.sv =====
// Bank of CHANNELS channels, each with two second-order exponential filter pairs.
// A step item (op 0) advances one channel by one time step and returns one result;
// a write item (op 1) loads one Q4.28 coefficient and returns nothing; items for a
// channel past the bank are dropped. Items enter a four-entry queue and are issued
// at up to one per cycle; a step item waits in the queue while a step of the same
// channel is still in the first four pipeline stages, so steps of one channel never
// overlap there, while steps of distinct channels run at one per cycle. After issue
// an item's state and coefficients are read, multiplied, rounded and summed into new
// state and a result in the output register. The pipeline stalls as a whole while
// the output register holds an untaken result. After reset a clearing pass over all
// channels zeroes coefficients and filter state; input ready stays low during it.
module dual_beta_synapse_filter_bank_core #(
    parameter int CHANNELS   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  dbsfb_pkg::t_in_item  i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output dbsfb_pkg::t_out_item o_out_item
);

    import dbsfb_pkg::*;

    logic     head_valid;
    t_in_item head;
    logic     pop;
    logic     clearing;

    dbsfb_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_item    (i_in_item),
        .i_hold       (clearing),
        .o_head_valid (head_valid),
        .o_head       (head),
        .i_pop        (pop)
    );

    dbsfb_back #(
        .CHANNELS   (CHANNELS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_clearing   (clearing),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_item   (o_out_item)
    );

endmodule
